>>> rtl/contiguous_frame_allocator_core_defines.svh
// assertion helpers used by the allocator core
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, checked on clk and masked while rst_n is low
`define CFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk and masked while rst_n is low
`define CFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cfa_pkg.sv
`default_nettype none

package cfa_pkg;

  localparam int MAX_FRAMES_DEF  = 4096;
  localparam int FRAME_SHIFT_DEF = 12;
  localparam int ADDR_BITS_DEF   = 24;

  localparam int BASE_W     = 12;
  localparam int FRAMES_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int MODE_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_FRAMES = 1'd1;

  localparam logic [BASE_W-1:0]   BASE_RST   = 12'd0;
  localparam logic [FRAMES_W-1:0] FRAMES_RST = 13'd4096;

  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;

  // busy map word and the slice scanned per search cycle
  localparam int WORD_W = 32;
  localparam int LANE_W = 8;

  typedef struct packed {
    logic load;
    logic srch_go;
    logic srch_step;
    logic prep;
    logic arm;
    logic mark_step;
  } cmd_t;

  typedef struct packed {
    logic need_zero;
    logic need_gt_n;
    logic is_alloc;
    logic is_range;
    logic in_range;
    logic hit;
    logic scan_end;
    logic mark_last;
  } sts_t;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/contiguous_frame_allocator_core.sv
`default_nettype none
// contiguous frame allocator: one busy bit per frame of a dma region
// request: start with in_mode (allocate, free, reserve), in_phys_addr and
//   in_length_bytes, taken at a clock edge where start is high and busy is low
// result: out_valid strobes for one cycle with out_ok, out_alloc_addr and
//   out_free_bytes; the receiver cannot stall, so the strobe is never held
// config: cfg_we writes cfg_wdata to register cfg_index (0 region base frame,
//   1 region frame count); a write clears the busy map and reloads the free count;
//   the user must see it made only while busy is low and no result is pending (unchecked)
// sequence from the accept edge, by controller state:
//   rejected request (zero length, bad mode, free / reserve starting outside the
//   region, allocate longer than the region): decode, then the result
//   free / reserve: decode, prep, arm, one mark step per busy-map word of 32
//   frames touched, flush; allocate: search over 8-frame slices, then prep to flush
//   allocate with no fit in the region: decode and search, then the result
// the first-fit scan reads each map word as four 8-frame lanes and checks 8 frames
// a cycle; marking does one read-modify-write of a map word per cycle
// one request at a time; a new request is taken in the strobe cycle
// reset: synchronous, clears the map (row valid bits) and sets the region
//   to its reset size at once, no clearing pass

module contiguous_frame_allocator_core #(
  parameter int MAX_FRAMES  = cfa_pkg::MAX_FRAMES_DEF,
  parameter int FRAME_SHIFT = cfa_pkg::FRAME_SHIFT_DEF,
  parameter int ADDR_BITS   = cfa_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [cfa_pkg::MODE_W-1:0]     in_mode,
  input  logic [ADDR_BITS-1:0]           in_phys_addr,
  input  logic [ADDR_BITS-1:0]           in_length_bytes,
  output logic                           out_valid,
  output logic                           out_ok,
  output logic [ADDR_BITS-1:0]           out_alloc_addr,
  output logic [ADDR_BITS:0]             out_free_bytes,
  input  logic                           cfg_we,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

`include "contiguous_frame_allocator_core_defines.svh"

  cfa_pkg::cmd_t cmd;
  cfa_pkg::sts_t sts;

  cfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid)
  );

  cfa_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .FRAME_SHIFT(FRAME_SHIFT),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_mode),
    .in_phys_addr   (in_phys_addr),
    .in_length_bytes(in_length_bytes),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_ok         (out_ok),
    .out_alloc_addr (out_alloc_addr),
    .out_free_bytes (out_free_bytes)
  );

  `CFA_ASSERT_NEXT(a_req_busy, (start && !busy), busy, "request accepted but block not busy")
  `CFA_ASSERT_NEXT(a_strobe_once, out_valid, !out_valid, "result strobe longer than one cycle")
  `CFA_ASSERT_NOW(a_strobe_idle, out_valid, !busy, "result strobe while request still running")
  `CFA_ASSERT_NOW(a_fail_addr, (out_valid && !out_ok), (out_alloc_addr == '0), "failed result with address")

endmodule

`default_nettype wire

>>> rtl/cfa_ram.sv
`default_nettype none

module cfa_ram #(
  parameter int WIDTH = cfa_pkg::WORD_W,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/cfa_dp.sv
`default_nettype none

module cfa_dp #(
  parameter int MAX_FRAMES  = cfa_pkg::MAX_FRAMES_DEF,
  parameter int FRAME_SHIFT = cfa_pkg::FRAME_SHIFT_DEF,
  parameter int ADDR_BITS   = cfa_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfa_pkg::cmd_t                  cmd,
  output cfa_pkg::sts_t                  sts,
  input  logic [cfa_pkg::MODE_W-1:0]     in_mode,
  input  logic [ADDR_BITS-1:0]           in_phys_addr,
  input  logic [ADDR_BITS-1:0]           in_length_bytes,
  input  logic                           cfg_we,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cfa_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                           out_ok,
  output logic [ADDR_BITS-1:0]           out_alloc_addr,
  output logic [ADDR_BITS:0]             out_free_bytes
);

  localparam int WORD_W  = cfa_pkg::WORD_W;
  localparam int LANE_W  = cfa_pkg::LANE_W;
  localparam int LANES   = WORD_W / LANE_W;
  localparam int LSEL_W  = $clog2(LANES);
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int LSB_W   = $clog2(LANE_W);
  localparam int WORDS   = (MAX_FRAMES + WORD_W - 1) / WORD_W;
  localparam int WA_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDX_W   = WA_W + BIT_W;
  localparam int SPACE_W = ADDR_BITS - FRAME_SHIFT;
  localparam int NEED_W  = SPACE_W + 1;
  localparam int N_W     = $clog2(MAX_FRAMES + 1);
  localparam int PC_W    = $clog2(WORD_W + 1);
  localparam int CW      = cfa_pkg::max2(cfa_pkg::max2(SPACE_W, IDX_W),
                                         cfa_pkg::max2(NEED_W, cfa_pkg::FRAMES_W)) + 2;
  localparam logic [ADDR_BITS:0] FRAME_RND = (ADDR_BITS+1)'((1 << FRAME_SHIFT) - 1);
  localparam logic [CW-1:0]      SPACE     = CW'(1) << SPACE_W;
  localparam logic [CW-1:0]      MAX_X     = CW'(MAX_FRAMES);

  // configuration and region size
  logic [cfa_pkg::BASE_W-1:0]   base_r, base_nxt, base_src;
  logic [cfa_pkg::FRAMES_W-1:0] frames_r, frames_nxt, frames_src;
  logic                         cfg_hit;
  logic [CW-1:0]                room_c, eff_c;
  logic [N_W-1:0]               n_r;
  logic [N_W-1:0]               free_cnt_r;
  logic [WORDS-1:0]             row_vld_r;

  // request
  logic [cfa_pkg::MODE_W-1:0] mode_r;
  logic [SPACE_W-1:0]         f_r;
  logic [NEED_W-1:0]          need_r;
  logic [ADDR_BITS:0]         len_sum;
  logic [CW-1:0]              need_x, n_x, rel_c;
  logic                       is_alloc_c, is_range_c;

  // scan and mark
  logic [WA_W-1:0]   word_r, word_nxt, last_word_r;
  logic [LSEL_W-1:0] lane_r;
  logic [N_W-1:0]    run_r, run_c;
  logic [LANE_W-1:0] lane_bits;
  logic [CW-1:0]     s_idx, hit_end_c, end_r, hi_r, hi_c, hi_m1, addr_sum;
  logic              hit_c, scan_end_c;
  logic [IDX_W-1:0]  lo_r;
  logic              set_r;
  logic [CW-1:0]     m_idx;
  logic [WORD_W-1:0] mask_c, chg_c, wdata_c, rd_data, word_data;
  logic              rd_vld_r;
  logic [PC_W-1:0]   pc_r;
  logic              pc_vld_r;
  logic              ok_r;
  logic [ADDR_BITS-1:0]      addr_r;
  logic [CW+FRAME_SHIFT-1:0] fb_w;

  always_comb begin
    base_nxt   = base_r;
    frames_nxt = frames_r;
    cfg_hit    = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        cfa_pkg::CFG_REGION_BASE: begin
          base_nxt = cfg_wdata[cfa_pkg::BASE_W-1:0];
          cfg_hit  = 1'b1;
        end
        cfa_pkg::CFG_REGION_FRAMES: begin
          frames_nxt = cfg_wdata[cfa_pkg::FRAMES_W-1:0];
          cfg_hit    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // effective size: region size limited by the map and by the address space
  always_comb begin
    base_src   = rst_n ? base_nxt : cfa_pkg::BASE_RST;
    frames_src = rst_n ? frames_nxt : cfa_pkg::FRAMES_RST;
    room_c     = (CW'(base_src) < SPACE) ? SPACE - CW'(base_src) : '0;
    eff_c      = CW'(frames_src);
    if (eff_c > MAX_X) begin
      eff_c = MAX_X;
    end
    if (eff_c > room_c) begin
      eff_c = room_c;
    end
  end

  assign len_sum    = {1'b0, in_length_bytes} + FRAME_RND;
  assign need_x     = CW'(need_r);
  assign n_x        = CW'(n_r);
  assign rel_c      = CW'(f_r) - CW'(base_r);
  assign is_alloc_c = (mode_r == cfa_pkg::MODE_ALLOC);

  always_comb begin
    is_range_c = mode_r inside {cfa_pkg::MODE_FREE, cfa_pkg::MODE_RESERVE};
  end

  // first-fit scan of one lane per cycle
  always_comb begin
    lane_bits = word_data[lane_r*LANE_W +: LANE_W];
    run_c     = run_r;
    hit_c     = 1'b0;
    hit_end_c = '0;
    s_idx     = '0;
    for (int k = 0; k < LANE_W; k++) begin
      s_idx = CW'({word_r, lane_r, LSB_W'(k)});
      if (s_idx < n_x && !hit_c) begin
        run_c = lane_bits[k] ? '0 : run_c + 1'b1;
        if (CW'(run_c) == need_x) begin
          hit_c     = 1'b1;
          hit_end_c = s_idx + 1'b1;
        end
      end
    end
    scan_end_c = (CW'({word_r, lane_r, LSB_W'(LANE_W-1)}) + 1'b1) >= n_x;
  end

  // range mask for the word under update
  always_comb begin
    mask_c = '0;
    m_idx  = '0;
    for (int k = 0; k < WORD_W; k++) begin
      m_idx     = CW'({word_r, BIT_W'(k)});
      mask_c[k] = (m_idx >= CW'(lo_r)) && (m_idx < hi_r);
    end
  end

  assign word_data = rd_vld_r ? rd_data : '0;
  assign chg_c     = mask_c & (word_data ^ {WORD_W{set_r}});
  assign wdata_c   = set_r ? (word_data | mask_c) : (word_data & ~mask_c);
  assign hi_c      = (end_r < n_x) ? end_r : n_x;
  assign hi_m1     = hi_c - 1'b1;
  assign addr_sum  = CW'(base_r) + CW'(lo_r);

  always_comb begin
    word_nxt = word_r;
    if (cmd.srch_go) begin
      word_nxt = '0;
    end else if (cmd.srch_step && lane_r == LSEL_W'(LANES - 1)) begin
      word_nxt = word_r + 1'b1;
    end else if (cmd.arm) begin
      word_nxt = lo_r[IDX_W-1:BIT_W];
    end else if (cmd.mark_step) begin
      word_nxt = word_r + 1'b1;
    end
  end

  cfa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (cmd.mark_step),
    .waddr(word_r),
    .wdata(wdata_c),
    .raddr(word_nxt),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= cfa_pkg::BASE_RST;
      frames_r   <= cfa_pkg::FRAMES_RST;
      n_r        <= N_W'(eff_c);
      free_cnt_r <= N_W'(eff_c);
      row_vld_r  <= '0;
      pc_vld_r   <= 1'b0;
    end else begin
      base_r   <= base_nxt;
      frames_r <= frames_nxt;
      n_r      <= N_W'(eff_c);
      pc_vld_r <= cmd.mark_step;
      if (cfg_hit) begin
        free_cnt_r <= N_W'(eff_c);
        row_vld_r  <= '0;
      end else begin
        if (pc_vld_r) begin
          free_cnt_r <= set_r ? free_cnt_r - N_W'(pc_r) : free_cnt_r + N_W'(pc_r);
        end
        if (cmd.mark_step) begin
          row_vld_r[word_r] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r   <= word_nxt;
    rd_vld_r <= row_vld_r[word_nxt];
    pc_r     <= PC_W'($countones(chg_c));
    if (cmd.load) begin
      mode_r <= in_mode;
      f_r    <= in_phys_addr[ADDR_BITS-1:FRAME_SHIFT];
      need_r <= len_sum[ADDR_BITS:FRAME_SHIFT];
      ok_r   <= 1'b0;
      addr_r <= '0;
    end
    if (cmd.srch_go) begin
      lane_r <= '0;
      run_r  <= '0;
    end
    if (cmd.srch_step) begin
      lane_r <= lane_r + 1'b1;
      run_r  <= run_c;
      if (hit_c) begin
        end_r <= hit_end_c;
      end
    end
    if (cmd.prep) begin
      ok_r  <= 1'b1;
      set_r <= (mode_r != cfa_pkg::MODE_FREE);
      if (is_alloc_c) begin
        lo_r <= IDX_W'(end_r - need_x);
      end else begin
        lo_r  <= IDX_W'(rel_c);
        end_r <= rel_c + need_x;
      end
    end
    if (cmd.arm) begin
      hi_r        <= hi_c;
      last_word_r <= hi_m1[IDX_W-1:BIT_W];
      if (is_alloc_c) begin
        addr_r <= {addr_sum[SPACE_W-1:0], {FRAME_SHIFT{1'b0}}};
      end
    end
  end

  assign sts.need_zero = (need_r == '0);
  assign sts.need_gt_n = (need_x > n_x);
  assign sts.is_alloc  = is_alloc_c;
  assign sts.is_range  = is_range_c;
  assign sts.in_range  = (CW'(f_r) >= CW'(base_r)) && (rel_c < n_x);
  assign sts.hit       = hit_c;
  assign sts.scan_end  = scan_end_c;
  assign sts.mark_last = (word_r == last_word_r);

  assign fb_w           = {CW'(free_cnt_r), {FRAME_SHIFT{1'b0}}};
  assign out_ok         = ok_r;
  assign out_alloc_addr = addr_r;
  assign out_free_bytes = fb_w[ADDR_BITS:0];

endmodule

`default_nettype wire

>>> rtl/cfa_ctrl.sv
`default_nettype none

module cfa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output cfa_pkg::cmd_t cmd,
  input  cfa_pkg::sts_t sts,
  output logic          out_valid
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEARCH,
    ST_PREP,
    ST_ARM,
    ST_MARK,
    ST_FLUSH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fail_c;

  assign fail_c = sts.need_zero
               || (!sts.is_alloc && !sts.is_range)
               || (sts.is_alloc && sts.need_gt_n)
               || (sts.is_range && !sts.in_range);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (fail_c) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end else if (sts.is_alloc) begin
          cmd.srch_go = 1'b1;
          state_nxt   = ST_SEARCH;
        end else begin
          state_nxt = ST_PREP;
        end
      end
      ST_SEARCH: begin
        cmd.srch_step = 1'b1;
        if (sts.hit) begin
          state_nxt = ST_PREP;
        end else if (sts.scan_end) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_ARM;
      end
      ST_ARM: begin
        cmd.arm   = 1'b1;
        state_nxt = ST_MARK;
      end
      ST_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
